### src/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property every clock outside reset
`define DTT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dedup target table assertion failed");

// Assert that a condition is followed by another in the next cycle
`define DTT_ASSERT_NEXT(label, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("dedup target table assertion failed");

`endif

### src/dtt_pkg.sv
// Shared types and constants of the dedup target table.
// No dependencies.
`default_nettype none

package dtt_pkg;

    localparam int MaxTargets  = 64;
    localparam int AddrW       = $clog2(MaxTargets);
    localparam int CntW        = AddrW + 1;
    localparam int MaxVantages = 16;
    localparam int VAddrW      = $clog2(MaxVantages);
    localparam int VCntW       = VAddrW + 1;

    typedef enum logic [2:0] {
        OP_INGEST   = 3'd0,
        OP_ACTIVATE = 3'd1,
        OP_DONE     = 3'd2,
        OP_DWELL    = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic CFG_DEDUP_RADIUS = 1'b0;
    localparam logic CFG_VISITED_TOL  = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dtt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } dtt_stat_t;

endpackage

`default_nettype wire

### src/dtt_ctrl.sv
// Controller state machine of the dedup target table.
// Depends on dtt_pkg; drives the datapath through dtt_cmd_t.
`default_nettype none

module dtt_ctrl
    import dtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire dtt_stat_t stat,
    output dtt_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Sequence load, scan, flush and commit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!stat.pipe_busy)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### src/dtt_datapath.sv
// Datapath of the dedup target table: entry and vantage memories, scan
// pipeline, commit logic and output register. Depends on dtt_pkg.
`default_nettype none

module dtt_datapath
    import dtt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dtt_cmd_t     cmd,
    output dtt_stat_t         stat,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [14:0]  cfg_data,
    input  wire logic [2:0]   in_op,
    input  wire logic [31:0]  in_id,
    input  wire logic [15:0]  in_x,
    input  wire logic [15:0]  in_y,
    input  wire logic [15:0]  in_z,
    input  wire logic [15:0]  in_radius,
    input  wire logic [15:0]  in_height,
    input  wire logic         in_los,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic              out_ok,
    output logic [31:0]       out_id,
    output logic [15:0]       out_x,
    output logic [15:0]       out_y,
    output logic [15:0]       out_z,
    output logic [15:0]       out_radius,
    output logic [15:0]       out_height,
    output logic [15:0]       out_dwells,
    output logic [6:0]        out_pending
);

    // Entry and vantage memories
    logic [31:0] mem_id     [MaxTargets];
    logic [15:0] mem_x      [MaxTargets];
    logic [15:0] mem_y      [MaxTargets];
    logic [15:0] mem_z      [MaxTargets];
    logic [15:0] mem_rad    [MaxTargets];
    logic [15:0] mem_hgt    [MaxTargets];
    logic [1:0]  mem_st     [MaxTargets];
    logic [15:0] mem_vx     [MaxVantages];
    logic [15:0] mem_vy     [MaxVantages];

    // Latched item
    logic [2:0]  op_reg;
    logic [31:0] id_reg;
    logic [15:0] x_reg, y_reg, z_reg, rad_reg, hgt_reg;
    logic        los_reg;

    // Control state
    logic [14:0]       dedup_reg, tol_reg;
    logic [29:0]       thr_reg;
    logic [CntW-1:0]   count_reg, count_next;
    logic [CntW-1:0]   notdone_reg, notdone_next;
    logic              av_reg, av_next;
    logic [AddrW-1:0]  aidx_reg, aidx_next;
    logic [VCntW-1:0]  vcount_reg, vcount_next;
    logic [15:0]       dwell_reg, dwell_next;
    logic [31:0]       aid_reg, aid_next;
    logic [15:0]       ax_reg, ay_reg, az_reg, arad_reg, ahgt_reg;
    logic [15:0]       ax_next, ay_next, az_next, arad_next, ahgt_next;

    // Scan pipeline
    logic [CntW-1:0]   cnt_reg;
    logic [CntW-1:0]   scan_len;
    logic              v1_reg, v2_reg;
    logic [AddrW-1:0]  idx1_reg, idx2_reg;
    logic [31:0]       q_id;
    logic [15:0]       q_x, q_y, q_z, q_rad, q_hgt, q_vx, q_vy;
    logic [1:0]        q_st;
    logic [15:0]       sx, sy;
    logic signed [16:0] dx, dy;
    logic signed [33:0] sqx_full, sqy_full;
    logic [31:0]       sqx_reg, sqy_reg;
    logic              ideq_reg, pend_reg;
    logic [31:0]       r2_id;
    logic [15:0]       r2_x, r2_y, r2_z, r2_rad, r2_hgt;
    logic [32:0]       dsq;
    logic              near, hit;
    logic              found_reg;
    logic [AddrW-1:0]  fidx_reg;
    logic [31:0]       f_id;
    logic [15:0]       f_x, f_y, f_z, f_rad, f_hgt;
    logic [14:0]       thr_src;
    logic [29:0]       thr_c;

    // Commit write port
    logic              row_we, st_we, van_we, ok_c;
    logic [AddrW-1:0]  wr_addr;
    logic [1:0]        st_data;

    logic              m_tvalid_reg;

    // Scan length per operation
    always_comb
    begin
        scan_len = '0;
        case (op_t'(op_reg))
            OP_INGEST:
                if (count_reg < CntW'(MaxTargets))
                    scan_len = count_reg;
            OP_ACTIVATE:
                if (!av_reg)
                    scan_len = count_reg;
            OP_QUERY:
                if (av_reg)
                    scan_len = CntW'(vcount_reg);
            default:
                scan_len = '0;
        endcase
    end

    assign stat.scan_done = cnt_reg >= scan_len;
    assign stat.pipe_busy = v1_reg | v2_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Square of the threshold for the current operation
    assign thr_src = (op_t'(op_reg) == OP_QUERY) ? tol_reg : dedup_reg;
    assign thr_c   = {15'd0, thr_src} * {15'd0, thr_src};

    // Stage two: distance components
    assign sx = (op_t'(op_reg) == OP_QUERY) ? q_vx : q_x;
    assign sy = (op_t'(op_reg) == OP_QUERY) ? q_vy : q_y;
    assign dx = $signed({sx[15], sx}) - $signed({x_reg[15], x_reg});
    assign dy = $signed({sy[15], sy}) - $signed({y_reg[15], y_reg});
    assign sqx_full = dx * dx;
    assign sqy_full = dy * dy;

    // Stage three: compare and match per operation
    assign dsq  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign near = dsq <= {3'd0, thr_reg};
    always_comb
    begin
        case (op_t'(op_reg))
            OP_INGEST:   hit = ideq_reg || (dedup_reg != '0 && near);
            OP_ACTIVATE: hit = pend_reg;
            OP_QUERY:    hit = near;
            default:     hit = 1'b0;
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            mem_id[wr_addr]  <= id_reg;
            mem_x[wr_addr]   <= x_reg;
            mem_y[wr_addr]   <= y_reg;
            mem_z[wr_addr]   <= z_reg;
            mem_rad[wr_addr] <= rad_reg;
            mem_hgt[wr_addr] <= hgt_reg;
        end
        if (st_we)
            mem_st[wr_addr] <= st_data;
        if (van_we)
        begin
            mem_vx[vcount_reg[VAddrW-1:0]] <= x_reg;
            mem_vy[vcount_reg[VAddrW-1:0]] <= y_reg;
        end
        q_id  <= mem_id[cnt_reg[AddrW-1:0]];
        q_x   <= mem_x[cnt_reg[AddrW-1:0]];
        q_y   <= mem_y[cnt_reg[AddrW-1:0]];
        q_z   <= mem_z[cnt_reg[AddrW-1:0]];
        q_rad <= mem_rad[cnt_reg[AddrW-1:0]];
        q_hgt <= mem_hgt[cnt_reg[AddrW-1:0]];
        q_st  <= mem_st[cnt_reg[AddrW-1:0]];
        q_vx  <= mem_vx[cnt_reg[VAddrW-1:0]];
        q_vy  <= mem_vy[cnt_reg[VAddrW-1:0]];
    end

    // Payload registers: item, pipeline data, found row
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            id_reg  <= in_id;
            x_reg   <= in_x;
            y_reg   <= in_y;
            z_reg   <= in_z;
            rad_reg <= in_radius;
            hgt_reg <= in_height;
            los_reg <= in_los;
        end
        thr_reg  <= thr_c;
        idx2_reg <= idx1_reg;
        sqx_reg  <= sqx_full[31:0];
        sqy_reg  <= sqy_full[31:0];
        ideq_reg <= q_id == id_reg;
        pend_reg <= q_st == ST_PENDING;
        r2_id    <= q_id;
        r2_x     <= q_x;
        r2_y     <= q_y;
        r2_z     <= q_z;
        r2_rad   <= q_rad;
        r2_hgt   <= q_hgt;
        if (v2_reg && hit && !found_reg)
        begin
            fidx_reg <= idx2_reg;
            f_id     <= r2_id;
            f_x      <= r2_x;
            f_y      <= r2_y;
            f_z      <= r2_z;
            f_rad    <= r2_rad;
            f_hgt    <= r2_hgt;
        end
    end

    // Commit: state updates and write port
    always_comb
    begin
        ok_c         = 1'b0;
        row_we       = 1'b0;
        st_we        = 1'b0;
        van_we       = 1'b0;
        wr_addr      = count_reg[AddrW-1:0];
        st_data      = ST_PENDING;
        count_next   = count_reg;
        notdone_next = notdone_reg;
        av_next      = av_reg;
        aidx_next    = aidx_reg;
        vcount_next  = vcount_reg;
        dwell_next   = dwell_reg;
        aid_next     = aid_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        az_next      = az_reg;
        arad_next    = arad_reg;
        ahgt_next    = ahgt_reg;
        case (op_t'(op_reg))
            OP_INGEST:
                if (!found_reg && count_reg < CntW'(MaxTargets))
                begin
                    ok_c         = 1'b1;
                    row_we       = cmd.commit;
                    st_we        = cmd.commit;
                    count_next   = count_reg + 1'b1;
                    notdone_next = notdone_reg + 1'b1;
                end
            OP_ACTIVATE:
                if (av_reg)
                    ok_c = 1'b1;
                else if (found_reg)
                begin
                    ok_c        = 1'b1;
                    st_we       = cmd.commit;
                    wr_addr     = fidx_reg;
                    st_data     = ST_ACTIVE;
                    av_next     = 1'b1;
                    aidx_next   = fidx_reg;
                    vcount_next = '0;
                    dwell_next  = '0;
                    aid_next    = f_id;
                    ax_next     = f_x;
                    ay_next     = f_y;
                    az_next     = f_z;
                    arad_next   = f_rad;
                    ahgt_next   = f_hgt;
                end
            OP_DONE:
            begin
                if (av_reg)
                begin
                    ok_c    = 1'b1;
                    st_we   = cmd.commit;
                    wr_addr = aidx_reg;
                    st_data = ST_DONE;
                    if (notdone_reg != '0)
                        notdone_next = notdone_reg - 1'b1;
                end
                av_next = 1'b0;
            end
            OP_DWELL:
                if (av_reg)
                begin
                    ok_c = 1'b1;
                    if (vcount_reg < VCntW'(MaxVantages))
                    begin
                        van_we      = cmd.commit;
                        vcount_next = vcount_reg + 1'b1;
                    end
                    if (los_reg && dwell_reg != 16'hFFFF)
                        dwell_next = dwell_reg + 1'b1;
                end
            OP_QUERY:
                ok_c = av_reg && found_reg;
            default:
                ok_c = 1'b0;
        endcase
    end

    // Result payload, loaded at commit
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_ok      <= ok_c;
            out_id      <= av_next ? aid_next : '0;
            out_x       <= av_next ? ax_next : '0;
            out_y       <= av_next ? ay_next : '0;
            out_z       <= av_next ? az_next : '0;
            out_radius  <= av_next ? arad_next : '0;
            out_height  <= av_next ? ahgt_next : '0;
            out_dwells  <= av_next ? dwell_next : '0;
            out_pending <= notdone_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dedup_reg    <= '0;
            tol_reg      <= 15'd50;
            count_reg    <= '0;
            notdone_reg  <= '0;
            av_reg       <= 1'b0;
            aidx_reg     <= '0;
            vcount_reg   <= '0;
            dwell_reg    <= '0;
            aid_reg      <= '0;
            ax_reg       <= '0;
            ay_reg       <= '0;
            az_reg       <= '0;
            arad_reg     <= '0;
            ahgt_reg     <= '0;
            cnt_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            idx1_reg     <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DEDUP_RADIUS)
                dedup_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_VISITED_TOL)
                tol_reg <= cfg_data;

            // Advance the scan address and valid pipe
            v1_reg   <= cmd.scan && !stat.scan_done;
            idx1_reg <= cnt_reg[AddrW-1:0];
            v2_reg   <= v1_reg;
            if (cmd.load)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan && !stat.scan_done)
                    cnt_reg <= cnt_reg + 1'b1;
                if (v2_reg && hit)
                    found_reg <= 1'b1;
            end

            if (cmd.commit)
            begin
                count_reg   <= count_next;
                notdone_reg <= notdone_next;
                av_reg      <= av_next;
                aidx_reg    <= aidx_next;
                vcount_reg  <= vcount_next;
                dwell_reg   <= dwell_next;
                aid_reg     <= aid_next;
                ax_reg      <= ax_next;
                ay_reg      <= ay_next;
                az_reg      <= az_next;
                arad_reg    <= arad_next;
                ahgt_reg    <= ahgt_next;
            end

            // Hold the result until taken
            if (cmd.commit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

### src/dedup_target_table.sv
// Each item passes the scan, flush and commit states; the scan covers the
// entries for ingest and activate, the vantages for query visited, and is
// empty for other items. Throughput: one item at a time; the scan over the
// entry memory, one entry per cycle through a three-stage pipeline, sets
// the item time. The result register lets the next item in while a result
// waits. Asynchronous active-low reset empties the table and the vantage
// store; no clearing pass is needed.
`default_nettype none

module dedup_target_table
    import dtt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [14:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target_id[31:0], pos_x[47:32], pos_y[63:48], pos_z[79:64],
    // radius[95:80], height[111:96], sight clear flag[112], zero pad
    input  wire logic [119:0] s_tdata,
    // op[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_id[31:0], out_x[47:32], out_y[63:48], out_z[79:64],
    // out_radius[95:80], out_height[111:96], clear_dwells[127:112],
    // pending_count[134:128], zero pad
    output logic [135:0]      m_tdata,
    // ok[0]
    output logic [0:0]        m_tuser
);

    dtt_cmd_t  cmd;
    dtt_stat_t stat;

    dtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser),
        .in_id       (s_tdata[31:0]),
        .in_x        (s_tdata[47:32]),
        .in_y        (s_tdata[63:48]),
        .in_z        (s_tdata[79:64]),
        .in_radius   (s_tdata[95:80]),
        .in_height   (s_tdata[111:96]),
        .in_los      (s_tdata[112]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_ok      (m_tuser[0]),
        .out_id      (m_tdata[31:0]),
        .out_x       (m_tdata[47:32]),
        .out_y       (m_tdata[63:48]),
        .out_z       (m_tdata[79:64]),
        .out_radius  (m_tdata[95:80]),
        .out_height  (m_tdata[111:96]),
        .out_dwells  (m_tdata[127:112]),
        .out_pending (m_tdata[134:128])
    );

    assign m_tdata[135] = 1'b0;

endmodule

`default_nettype wire

### src/dtt_checker.sv
// Port-level checker of the dedup target table, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dtt_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [0:0]   m_tuser
);

    // Stalled result holds
    `DTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Pending count never exceeds the table depth
    `DTT_ASSERT(a_pending_range, !m_tvalid || m_tdata[134:128] <= 7'd64)

    // An accepted item closes the input until its result is produced
    `DTT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // Padding bit of a result stays zero
    `DTT_ASSERT(a_pad_zero, !m_tvalid || !m_tdata[135])

endmodule

bind dedup_target_table dtt_checker u_dtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
